### hw/rtl/frst_pkg.sv
// Shared constants, codes and types of the frame range step timer.
`timescale 1ns / 1ps
`default_nettype none

package frst_pkg;

    localparam int TIME_BITS   = 32;
    localparam int MAX_CATCHUP = 32;
    localparam int CNT_W       = $clog2(MAX_CATCHUP + 1);
    localparam int CMP_W       = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int APB_AW      = 5;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_PROG  = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_FIN   = 3'd3;
    localparam logic [2:0] ACT_SHIFT = 3'd4;

    localparam logic [1:0] EV_FRAME  = 2'd0;
    localparam logic [1:0] EV_START  = 2'd1;
    localparam logic [1:0] EV_FINISH = 2'd2;
    localparam logic [1:0] EV_STOP   = 2'd3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_STOP = 2'd3;

    localparam logic [2:0] REG_DELAY   = 3'd0;
    localparam logic [2:0] REG_FIRST   = 3'd1;
    localparam logic [2:0] REG_FINAL   = 3'd2;
    localparam logic [2:0] REG_LIMIT   = 3'd3;
    localparam logic [2:0] REG_FOREVER = 3'd4;

    typedef struct packed {
        logic [31:0] frame_delay;
        logic [15:0] first_frame;
        logic [15:0] final_frame;
        logic [15:0] repeat_limit;
        logic        repeat_forever;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
    } t_qent;

endpackage

`default_nettype wire

### hw/rtl/frst_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module frst_cfg
    import frst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_delay    <= 32'd1;
            r_cfg.first_frame    <= 16'd0;
            r_cfg.final_frame    <= 16'd0;
            r_cfg.repeat_limit   <= 16'd1;
            r_cfg.repeat_forever <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DELAY:   r_cfg.frame_delay    <= pwdata;
                REG_FIRST:   r_cfg.first_frame    <= pwdata[15:0];
                REG_FINAL:   r_cfg.final_frame    <= pwdata[15:0];
                REG_LIMIT:   r_cfg.repeat_limit   <= pwdata[15:0];
                REG_FOREVER: r_cfg.repeat_forever <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DELAY:   prdata = r_cfg.frame_delay;
            REG_FIRST:   prdata = {16'd0, r_cfg.first_frame};
            REG_FINAL:   prdata = {16'd0, r_cfg.final_frame};
            REG_LIMIT:   prdata = {16'd0, r_cfg.repeat_limit};
            REG_FOREVER: prdata = {31'd0, r_cfg.repeat_forever};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/frst_front.sv
// Front end: accepts requests, drops undefined actions and builds queue entries.
`timescale 1ns / 1ps
`default_nettype none

module frst_front
    import frst_pkg::*;
(
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,
    input  wire logic [2:0]  i_s_tuser,
    input  wire logic        i_full,
    output logic             o_push,
    output t_qent            o_ent
);

    logic w_known;

    assign w_known = (i_s_tuser == ACT_START) || (i_s_tuser == ACT_PROG) ||
                     (i_s_tuser == ACT_STOP)  || (i_s_tuser == ACT_FIN)  ||
                     (i_s_tuser == ACT_SHIFT);

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full && w_known;
    assign o_ent.op   = i_s_tuser;
    // carry the shift for a time shift, the timestamp otherwise
    assign o_ent.value = (i_s_tuser == ACT_SHIFT) ? i_s_tdata[63:32] : i_s_tdata[31:0];

endmodule

`default_nettype wire

### hw/rtl/frst_queue.sv
// Short request queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module frst_queue
    import frst_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_ent,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_qent      o_head
);

    t_qent            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_AW:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW + 1)'(w_push) - (Q_AW + 1)'(w_pop);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/frst_back.sv
// Back end: sequence state, catch-up stepping and result output.
`timescale 1ns / 1ps
`default_nettype none

module frst_back
    import frst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_empty,
    input  wire t_qent       i_head,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,
    output logic [1:0]       o_m_tuser,
    output logic             o_m_tlast
);

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_START2 = 3'd1;
    localparam logic [2:0] B_LOOP   = 3'd2;
    localparam logic [2:0] B_FIN    = 3'd3;
    localparam logic [2:0] B_FLUSH  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_status, n_status;
    logic [TIME_BITS-1:0] r_lst, n_lst;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [15:0]          r_frame, n_frame;
    logic [15:0]          r_rep, n_rep;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    logic        r_pv;
    logic [1:0]  r_pk;
    logic [15:0] r_pf;
    logic [15:0] r_pr;

    logic        r_ov;
    logic [1:0]  r_ok;
    logic [15:0] r_of;
    logic [15:0] r_or;
    logic        r_ol;

    logic                 w_out_free;
    logic                 w_can_push;
    logic                 w_push;
    logic [1:0]           w_push_kind;
    logic [15:0]          w_push_frame;
    logic [15:0]          w_push_rep;
    logic                 w_flush;
    logic                 w_load_out;
    logic [TIME_BITS-1:0] w_q_now;
    logic [TIME_BITS-1:0] w_diff;
    logic                 w_due;
    logic [15:0]          w_step_frame;
    logic [15:0]          w_rep_inc;

    assign w_out_free   = !r_ov || i_m_tready;
    assign w_can_push   = !r_pv || w_out_free;
    assign w_q_now      = TIME_BITS'(i_head.value);
    assign w_diff       = r_now - r_lst;
    assign w_due        = (r_now > r_lst) &&
                          (CMP_W'(w_diff) >= CMP_W'(i_cfg.frame_delay)) &&
                          (r_cnt < CNT_W'(MAX_CATCHUP));
    assign w_step_frame = (r_frame == i_cfg.final_frame) ? i_cfg.first_frame
                                                         : r_frame + 16'd1;
    assign w_rep_inc    = r_rep + 16'd1;
    assign w_load_out   = (w_push && r_pv) || w_flush;

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_lst        = r_lst;
        n_now        = r_now;
        n_frame      = r_frame;
        n_rep        = r_rep;
        n_cnt        = r_cnt;
        o_pop        = 1'b0;
        w_push       = 1'b0;
        w_push_kind  = EV_FRAME;
        w_push_frame = r_frame;
        w_push_rep   = r_rep;
        w_flush      = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        ACT_START: begin
                            n_lst        = w_q_now;
                            n_status     = ST_RUN;
                            n_frame      = i_cfg.first_frame;
                            n_rep        = 16'd0;
                            w_push       = 1'b1;
                            w_push_kind  = EV_START;
                            w_push_frame = i_cfg.first_frame;
                            w_push_rep   = 16'd0;
                            n_state      = B_START2;
                        end
                        ACT_PROG: begin
                            if (r_status == ST_RUN) begin
                                n_now   = w_q_now;
                                n_cnt   = '0;
                                n_state = B_LOOP;
                            end
                        end
                        ACT_STOP, ACT_FIN: begin
                            if (r_status == ST_RUN) begin
                                w_push = 1'b1;
                                if (i_head.op == ACT_STOP) begin
                                    n_status    = ST_STOP;
                                    w_push_kind = EV_STOP;
                                end else begin
                                    n_status    = ST_FIN;
                                    w_push_kind = EV_FINISH;
                                end
                                n_state = B_FLUSH;
                            end
                        end
                        ACT_SHIFT: begin
                            n_lst = r_lst + TIME_BITS'(i_head.value);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_START2: begin
                if (w_can_push) begin
                    w_push  = 1'b1;
                    n_state = B_FLUSH;
                end
            end
            B_LOOP: begin
                if (w_can_push) begin
                    if (w_due) begin
                        n_frame      = w_step_frame;
                        n_lst        = r_lst + TIME_BITS'(i_cfg.frame_delay);
                        n_cnt        = r_cnt + 1'b1;
                        w_push       = 1'b1;
                        w_push_frame = w_step_frame;
                        // frame result shows the count before this repetition
                        if (w_step_frame == i_cfg.final_frame && !i_cfg.repeat_forever) begin
                            n_rep = w_rep_inc;
                            if (w_rep_inc == i_cfg.repeat_limit) begin
                                n_status = ST_FIN;
                                n_state  = B_FIN;
                            end
                        end
                    end else begin
                        n_state = B_FLUSH;
                    end
                end
            end
            B_FIN: begin
                if (w_can_push) begin
                    w_push      = 1'b1;
                    w_push_kind = EV_FINISH;
                    n_state     = B_FLUSH;
                end
            end
            B_FLUSH: begin
                if (!r_pv) begin
                    n_state = B_IDLE;
                end else if (w_out_free) begin
                    w_flush = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_status <= ST_IDLE;
            r_lst    <= '0;
            r_now    <= '0;
            r_frame  <= '0;
            r_rep    <= '0;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_lst    <= n_lst;
            r_now    <= n_now;
            r_frame  <= n_frame;
            r_rep    <= n_rep;
            r_cnt    <= n_cnt;
            if (w_push) begin
                r_pv <= 1'b1;
            end else if (w_flush) begin
                r_pv <= 1'b0;
            end
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_pk <= w_push_kind;
            r_pf <= w_push_frame;
            r_pr <= w_push_rep;
        end
        if (w_load_out) begin
            r_ok <= r_pk;
            r_of <= r_pf;
            r_or <= r_pr;
            r_ol <= w_flush;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_or, r_of};
    assign o_m_tuser  = r_ok;
    assign o_m_tlast  = r_ol;

endmodule

`default_nettype wire

### hw/rtl/frame_range_step_timer.sv
// Top level of the frame range step timer.
`timescale 1ns / 1ps
`default_nettype none

// Timestamp-driven frame sequencer. Requests are taken in the cycle they are
// offered unless the two-entry queue is full; undefined actions are dropped,
// and the back end works through the rest one at a time. A time shift or an
// ignored request is handled in the idle state, a stop or finish is followed by
// a flush state, a start by a second push state and a flush; a progress
// request is accepted, then steps one frame at a time up to MAX_CATCHUP (32)
// steps, gives the finish result or ends catch-up, and closes in a flush. The
// single shared step unit and the output register pass one result per cycle
// while the output is not stalled. Results leave through a pending slot and an
// output register so that the last result of a request carries tlast.

module frame_range_step_timer
    import frst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [63:0]       i_s_tdata,  // time_value, shift_amount
    input  wire logic [2:0]        i_s_tuser,  // action
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [31:0]       o_m_tdata,  // frame_number, repeat_number
    output logic      [1:0]        o_m_tuser,  // event_kind
    output logic                   o_m_tlast,  // last_result
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_cfg  w_cfg;
    t_qent w_ent;
    t_qent w_head;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;

    frst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    frst_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_ent      (w_ent)
    );

    frst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_ent),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    frst_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/frst_checker.sv
// Port-level checker for the frame range step timer and its bind.
`timescale 1ns / 1ps
`default_nettype none

module frst_checker
    import frst_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [31:0]       o_m_tdata,
    input wire logic [1:0]        o_m_tuser,
    input wire logic              o_m_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == EV_START |-> !o_m_tlast)
        else $error("started result closed a request");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == EV_STOP || o_m_tuser == EV_FINISH) |-> o_m_tlast)
        else $error("stop or finish result not last");

    a_start_then_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser == EV_START |=>
        !o_m_tvalid || o_m_tuser == EV_FRAME)
        else $error("started result not followed by a frame");

endmodule

bind frame_range_step_timer frst_checker u_frst_checker (.*);

`default_nettype wire

### dv/frame_range_step_timer_tb.sv
// Self-checking testbench of the frame range step timer: stream traffic, APB setup, result check.
`timescale 1ns / 1ps

module frame_range_step_timer_tb;
    import frst_pkg::*;

    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int QUIET_CYCLES = 60;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] frame;
        logic [15:0] reps;
        logic        last;
    } t_event;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [63:0]          i_s_tdata  = '0;  // time_value, shift_amount
    logic [2:0]           i_s_tuser  = '0;  // action
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [31:0]          o_m_tdata;        // frame_number, repeat_number
    logic [1:0]           o_m_tuser;        // event_kind
    logic                 o_m_tlast;        // last_result
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [APB_AW-1:0]    paddr      = '0;
    logic [31:0]          pwdata     = '0;
    logic [31:0]          prdata;
    logic                 pready;

    t_cfg        timer_cfg;
    logic [31:0] seq_time;
    logic [15:0] seq_frame;
    logic [15:0] seq_reps;
    logic [1:0]  seq_status;
    t_event      frame_events_due[$];
    t_event      held_event;
    logic        have_held;
    t_event      want_event;
    t_event      seen_event;
    int          useful_sent = 0;
    int          fault_count = 0;
    int          stall_cycles;
    logic        calm = 1'b0;

    frame_range_step_timer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_event = '{o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16], o_m_tlast};
            if (frame_events_due.size() == 0) begin
                $display("%0t: unexpected result kind %0d frame %0d repeat %0d last %0d",
                         $time, seen_event.kind, seen_event.frame, seen_event.reps,
                         seen_event.last);
                fault_count++;
            end else begin
                want_event = frame_events_due.pop_front();
                if (seen_event !== want_event) begin
                    $display({"%0t: expected kind %0d frame %0d repeat %0d last %0d, ",
                              "got kind %0d frame %0d repeat %0d last %0d"},
                             $time, want_event.kind, want_event.frame, want_event.reps,
                             want_event.last, seen_event.kind, seen_event.frame,
                             seen_event.reps, seen_event.last);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (psel && penable && pwrite && pready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic emit_event(input logic [1:0] kind);
        if (have_held)
            frame_events_due.push_back(held_event);
        held_event = '{kind, seq_frame, seq_reps, 1'b0};
        have_held = 1'b1;
    endtask

    task automatic step_sequencer(input logic [2:0] act, input logic [31:0] now,
                                  input logic [31:0] shift);
        int          steps;
        logic        done;
        logic [31:0] elapsed;
        have_held = 1'b0;
        case (act)
            ACT_START: begin
                seq_time   = now;
                seq_status = ST_RUN;
                seq_frame  = timer_cfg.first_frame;
                seq_reps   = '0;
                emit_event(EV_START);
                emit_event(EV_FRAME);
                useful_sent++;
            end
            ACT_PROG: begin
                if (seq_status == ST_RUN) begin
                    useful_sent++;
                    steps = 0;
                    done  = 1'b0;
                    while (!done && steps < MAX_CATCHUP) begin
                        elapsed = now - seq_time;
                        if (now > seq_time && elapsed >= timer_cfg.frame_delay) begin
                            if (seq_frame == timer_cfg.final_frame)
                                seq_frame = timer_cfg.first_frame;
                            else
                                seq_frame = seq_frame + 16'd1;
                            seq_time = seq_time + timer_cfg.frame_delay;
                            emit_event(EV_FRAME);
                            if (seq_frame == timer_cfg.final_frame &&
                                !timer_cfg.repeat_forever) begin
                                seq_reps = seq_reps + 16'd1;
                                if (seq_reps == timer_cfg.repeat_limit) begin
                                    seq_status = ST_FIN;
                                    emit_event(EV_FINISH);
                                    done = 1'b1;
                                end
                            end
                            steps++;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
            ACT_STOP, ACT_FIN: begin
                if (seq_status == ST_RUN) begin
                    seq_status = (act == ACT_STOP) ? ST_STOP : ST_FIN;
                    emit_event((act == ACT_STOP) ? EV_STOP : EV_FINISH);
                    useful_sent++;
                end
            end
            ACT_SHIFT: begin
                seq_time = seq_time + shift;
                useful_sent++;
            end
            default: ;
        endcase
        if (have_held) begin
            held_event.last = 1'b1;
            frame_events_due.push_back(held_event);
        end
    endtask

    task automatic send_request(input logic [2:0] act, input logic [31:0] time_value,
                                input logic [31:0] shift_amount);
        if (!calm) begin
            while ($urandom_range(0, 99) < 35) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {shift_amount, time_value};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        step_sequencer(act, time_value, shift_amount);
    endtask

    // hold the sender until every result is back, then let the back end drain
    task automatic settle_block(input int tail);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (frame_events_due.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_DELAY:   timer_cfg.frame_delay    = value;
            REG_FIRST:   timer_cfg.first_frame    = value[15:0];
            REG_FINAL:   timer_cfg.final_frame    = value[15:0];
            REG_LIMIT:   timer_cfg.repeat_limit   = value[15:0];
            REG_FOREVER: timer_cfg.repeat_forever = value[0];
            default: ;
        endcase
    endtask

    task automatic test_idle_requests();
        send_request(ACT_PROG, 32'd5, 32'd0);
        send_request(ACT_STOP, 32'd0, 32'd0);
        send_request(ACT_FIN, 32'd0, 32'd0);
        send_request(ACT_RSVD5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_RSVD7, 32'd0, 32'd0);
        send_request(ACT_SHIFT, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_default_config();
        send_request(ACT_START, 32'd0, 32'd0);
        send_request(ACT_PROG, 32'd3, 32'd0);
    endtask

    task automatic test_range_and_repeats();
        settle_block(QUIET_CYCLES);
        write_register(REG_DELAY, 32'd10);
        write_register(REG_FIRST, 32'd3);
        write_register(REG_FINAL, 32'd5);
        write_register(REG_LIMIT, 32'd2);
        write_register(REG_FOREVER, 32'd0);
        send_request(ACT_START, 32'd100, 32'd0);
        send_request(ACT_PROG, 32'd125, 32'd0);
        send_request(ACT_PROG, 32'd1000, 32'd0);
        send_request(ACT_STOP, 32'd0, 32'd0);
    endtask

    task automatic test_stop_and_finish();
        send_request(ACT_START, 32'd7, 32'd0);
        send_request(ACT_STOP, 32'd0, 32'd0);
        send_request(ACT_START, 32'd0, 32'd0);
        send_request(ACT_FIN, 32'd0, 32'd0);
    endtask

    task automatic test_catchup_cap();
        settle_block(QUIET_CYCLES);
        write_register(REG_DELAY, 32'd0);
        write_register(REG_FIRST, 32'd0);
        write_register(REG_FINAL, 32'd2);
        write_register(REG_FOREVER, 32'd1);
        calm = 1'b1;
        send_request(ACT_START, 32'd10, 32'd0);
        send_request(ACT_PROG, 32'd11, 32'd0);
        send_request(ACT_PROG, 32'd11, 32'd0);
        settle_block(1);
        calm = 1'b0;
    endtask

    task automatic test_extreme_fields();
        settle_block(QUIET_CYCLES);
        write_register(REG_DELAY, 32'hFFFF_FFFF);
        write_register(REG_FIRST, 32'h0000_FFFE);
        write_register(REG_FINAL, 32'h0000_0001);
        write_register(REG_LIMIT, 32'h0000_FFFF);
        write_register(REG_FOREVER, 32'd0);
        send_request(ACT_START, 32'd0, 32'd0);
        send_request(ACT_PROG, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_SHIFT, 32'd0, 32'd1);
        send_request(ACT_PROG, 32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic test_repeat_limit_lowered();
        settle_block(QUIET_CYCLES);
        write_register(REG_DELAY, 32'd1);
        write_register(REG_FIRST, 32'd0);
        write_register(REG_FINAL, 32'd0);
        write_register(REG_LIMIT, 32'd3);
        send_request(ACT_START, 32'd0, 32'd0);
        send_request(ACT_PROG, 32'd2, 32'd0);
        settle_block(QUIET_CYCLES);
        write_register(REG_LIMIT, 32'd1);
        send_request(ACT_PROG, 32'd4, 32'd0);
        settle_block(QUIET_CYCLES);
        write_register(REG_LIMIT, 32'd0);
        send_request(ACT_PROG, 32'd6, 32'd0);
    endtask

    task automatic test_random_sequences();
        int          target;
        int          phase;
        int          n;
        int          r;
        logic [2:0]  act;
        logic [31:0] clock_now;
        logic [31:0] d;
        logic [31:0] adv;
        logic [31:0] sh;
        target    = useful_sent + 70;
        phase     = 0;
        clock_now = '0;
        while (useful_sent < target) begin
            settle_block(QUIET_CYCLES);
            r = $urandom_range(0, 99);
            write_register(REG_DELAY, (r < 10) ? 32'd0 : (r < 20) ? $urandom
                                               : $urandom_range(1, 9));
            r = $urandom_range(0, 99);
            write_register(REG_FIRST, (r < 15) ? 32'h0000_FFFF - $urandom_range(0, 3)
                                               : $urandom_range(0, 40));
            r = $urandom_range(0, 99);
            write_register(REG_FINAL, (r < 20) ? $urandom_range(0, 65535)
                           : {16'd0, timer_cfg.first_frame + 16'($urandom_range(0, 6))});
            r = $urandom_range(0, 99);
            write_register(REG_LIMIT, (r < 10) ? 32'd0 : (r < 15) ? 32'h0000_FFFF
                                               : $urandom_range(1, 4));
            write_register(REG_FOREVER, ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0);
            calm = (phase == 1);
            d = timer_cfg.frame_delay;
            for (n = 0; n < 25 && useful_sent < target; n++) begin
                r = $urandom_range(0, 99);
                if (seq_status != ST_RUN || r < 6) begin
                    r = $urandom_range(0, 3);
                    clock_now = (r == 0) ? $urandom_range(0, 1000)
                              : (r == 1) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                              : $urandom;
                    send_request(ACT_START, clock_now, $urandom);
                end else if (r < 66) begin
                    if (d > 1000)
                        adv = $urandom_range(0, 1) ? d : $urandom_range(0, 1000);
                    else if ($urandom_range(0, 19) == 0)
                        adv = d * 40;
                    else
                        adv = $urandom_range(0, 4 * d + 3);
                    clock_now = clock_now + adv;
                    send_request(ACT_PROG, clock_now, $urandom);
                end else if (r < 74) begin
                    sh = ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, 20);
                    send_request(ACT_SHIFT, $urandom, sh);
                end else if (r < 82) begin
                    act = $urandom_range(0, 1) ? ACT_STOP : ACT_FIN;
                    send_request(act, $urandom, $urandom);
                end else if (r < 92) begin
                    act = 3'($urandom_range(1, 7));
                    send_request(act, $urandom, $urandom);
                end else begin
                    settle_block(1);
                end
            end
            phase++;
        end
        calm = 1'b0;
    endtask

    initial begin
        timer_cfg  = '{32'd1, 16'd0, 16'd0, 16'd1, 1'b0};
        seq_time   = '0;
        seq_frame  = '0;
        seq_reps   = '0;
        seq_status = ST_IDLE;
        have_held  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_requests();
        test_default_config();
        test_range_and_repeats();
        test_stop_and_finish();
        test_catchup_cap();
        test_extreme_fields();
        test_repeat_limit_lowered();
        test_random_sequences();
        settle_block(QUIET_CYCLES);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/frst_pkg.sv
hw/rtl/frst_cfg.sv
hw/rtl/frst_front.sv
hw/rtl/frst_queue.sv
hw/rtl/frst_back.sv
hw/rtl/frame_range_step_timer.sv
hw/rtl/frst_checker.sv
dv/frame_range_step_timer_tb.sv
